[sv/rsd_pkg.sv]
// Package with the payload types, internal stage types and constants of the rounded scaled divider.
package rsd_pkg;

    localparam int unsigned DataWidth  = 32;
    localparam int unsigned ExpWidth   = 6;
    localparam int unsigned ShiftWidth = 5;
    localparam logic [ExpWidth-1:0] ExpMin = ExpWidth'(1);
    localparam logic [ExpWidth-1:0] ExpMax = ExpWidth'(32);

    // One input item as it arrives on the command port.
    typedef struct packed {
        logic [DataWidth-1:0] dividend;
        logic [ExpWidth-1:0]  shift_exponent;
        logic [DataWidth-1:0] odd_factor;
        logic [DataWidth-1:0] product_factor_first;
        logic [DataWidth-1:0] product_factor_second;
    } rsd_in_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [DataWidth-1:0] rounded_quotient;
        logic                 zero_divisor;
    } rsd_out_t;

    // Working set carried through the division stages.
    typedef struct packed {
        logic [DataWidth-1:0] num;
        logic [DataWidth-1:0] den;
        logic [DataWidth-1:0] rem;
        logic [DataWidth-1:0] quo;
        logic                 zero;
    } rsd_div_t;

endpackage

[sv/rsd_denom.sv]
// Two-stage front end that builds the wrapped 32-bit denominator.
module rsd_denom (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rsd_pkg::rsd_in_t  in_data,
    output logic              out_valid,
    output rsd_pkg::rsd_div_t out_data
);
    import rsd_pkg::*;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [DataWidth-1:0]  s1_num_reg;
    logic [DataWidth-1:0]  s1_odd_reg;
    logic [DataWidth-1:0]  s1_prod_reg;
    logic [ShiftWidth-1:0] s1_shamt_reg;
    logic [DataWidth-1:0]  s1_odd_next;
    logic [DataWidth-1:0]  s1_prod_next;
    logic [ShiftWidth-1:0] s1_shamt_next;
    logic [ExpWidth-1:0]   exp_clamped;

    logic                  s2_valid_reg;
    rsd_div_t              s2_data_reg;
    rsd_div_t              s2_data_next;
    logic [DataWidth-1:0]  scaled_odd;
    logic [DataWidth-1:0]  den_full;

    // First stage: odd factor, the b*c+1 product and the clamped shift amount.
    always_comb
    begin
        s1_valid_next = in_valid;
        s1_odd_next   = {in_data.odd_factor[DataWidth-2:0], 1'b1};
        s1_prod_next  = DataWidth'(in_data.product_factor_first
                                   * in_data.product_factor_second) + DataWidth'(1);
        if (in_data.shift_exponent < ExpMin)
        begin
            exp_clamped = ExpMin;
        end
        else if (in_data.shift_exponent > ExpMax)
        begin
            exp_clamped = ExpMax;
        end
        else
        begin
            exp_clamped = in_data.shift_exponent;
        end
        s1_shamt_next = ShiftWidth'(exp_clamped - ExpMin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_num_reg   <= in_data.dividend;
        s1_odd_reg   <= s1_odd_next;
        s1_prod_reg  <= s1_prod_next;
        s1_shamt_reg <= s1_shamt_next;
    end

    // Second stage: scale by the power of two, then multiply by the product term.
    always_comb
    begin
        scaled_odd         = s1_odd_reg << s1_shamt_reg;
        den_full           = DataWidth'(scaled_odd * s1_prod_reg);
        s2_data_next.num   = s1_num_reg;
        s2_data_next.den   = den_full;
        s2_data_next.rem   = '0;
        s2_data_next.quo   = '0;
        s2_data_next.zero  = (den_full == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_data_reg <= s2_data_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

[sv/rsd_div_step.sv]
// One restoring division stage that settles a single quotient bit.
module rsd_div_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rsd_pkg::rsd_div_t in_data,
    output logic              out_valid,
    output rsd_pkg::rsd_div_t out_data
);
    import rsd_pkg::*;

    logic                 valid_reg;
    rsd_div_t             data_reg;
    rsd_div_t             data_next;
    logic [DataWidth:0]   trial;
    logic [DataWidth+1:0] diff;

    // Bring down the next dividend bit and try to subtract the divisor.
    always_comb
    begin
        trial          = {in_data.rem, in_data.num[DataWidth-1]};
        diff           = {1'b0, trial} - {2'b00, in_data.den};
        data_next      = in_data;
        data_next.num  = {in_data.num[DataWidth-2:0], 1'b0};
        if (!diff[DataWidth+1])
        begin
            data_next.rem = diff[DataWidth-1:0];
            data_next.quo = {in_data.quo[DataWidth-2:0], 1'b1};
        end
        else
        begin
            data_next.rem = trial[DataWidth-1:0];
            data_next.quo = {in_data.quo[DataWidth-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef NO_ASSERTIONS
    // The partial remainder must stay below a non-zero divisor after every step.
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.zero |-> data_reg.rem < data_reg.den)
        else $error("partial remainder not below divisor");
`endif

endmodule

[sv/rsd_round.sv]
// Output stage that rounds the quotient and handles the zero divisor.
module rsd_round (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rsd_pkg::rsd_div_t in_data,
    output logic              out_valid,
    output rsd_pkg::rsd_out_t out_data
);
    import rsd_pkg::*;

    logic     valid_reg;
    rsd_out_t data_reg;
    rsd_out_t data_next;

    // Round up only when the remainder is strictly above half the divisor.
    always_comb
    begin
        data_next.zero_divisor = in_data.zero;
        if (in_data.zero)
        begin
            data_next.rounded_quotient = '0;
        end
        else if (in_data.rem > (in_data.den >> 1))
        begin
            data_next.rounded_quotient = in_data.quo + DataWidth'(1);
        end
        else
        begin
            data_next.rounded_quotient = in_data.quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[sv/rounded_scaled_divider.sv]
// Top level of the rounded scaled divider: denominator front end, bit-per-stage divider, rounding.
// Path: the start transfer passes through two denominator stages, 32 divider stages and one
// rounding stage, and the done strobe comes from the rounding stage's register.
// Throughput: one item per cycle; busy stays low, and every pipeline stage moves each cycle.
// Reset clears all valid bits at once; items in flight at reset are dropped.
module rounded_scaled_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rsd_pkg::rsd_in_t  operands,
    output logic              done,
    output rsd_pkg::rsd_out_t result
);
    import rsd_pkg::*;

    // Edges from the start transfer to the edge that accepts the result.
    localparam int unsigned Latency = DataWidth + 3;

    logic     accept;
    logic     den_valid;
    rsd_div_t den_data;
    logic     step_valid [DataWidth+1];
    rsd_div_t step_data  [DataWidth+1];

    // The pipeline never stalls, so a start is always taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Denominator construction.
    rsd_denom u_denom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_data   (operands),
        .out_valid (den_valid),
        .out_data  (den_data)
    );

    assign step_valid[0] = den_valid;
    assign step_data[0]  = den_data;

    // One quotient bit per stage, most significant first.
    for (genvar i = 0; i < DataWidth; i++)
    begin : g_step
        rsd_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (step_valid[i]),
            .in_data   (step_data[i]),
            .out_valid (step_valid[i+1]),
            .out_data  (step_data[i+1])
        );
    end

    // Final rounding and result register.
    rsd_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (step_valid[DataWidth]),
        .in_data   (step_data[DataWidth]),
        .out_valid (done),
        .out_data  (result)
    );

`ifndef NO_ASSERTIONS
    // Every transfer produces exactly one strobe after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##Latency done)
        else $error("result strobe missing after fixed latency");

    // A zero divisor always yields a zero quotient.
    a_zero_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.zero_divisor |-> result.rounded_quotient == '0)
        else $error("non-zero quotient reported with zero divisor");

    // A valid divider output must reach the done strobe through the result register.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid[DataWidth] |=> done)
        else $error("divider output lost before result register");
`endif

endmodule
